/* design/lmc_pkg.sv */
package lmc_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_RAN     = 3'd0,
    ST_OUTPUT  = 3'd1,
    ST_HALTED  = 3'd2,
    ST_BADOP   = 3'd3,
    ST_RANGE   = 3'd4,
    ST_STOPPED = 3'd5,
    ST_LOADED  = 3'd6
  } status_e;

  // Instruction hundreds digit
  localparam logic [3:0] OPC_HALT = 4'd0;
  localparam logic [3:0] OPC_ADD  = 4'd1;
  localparam logic [3:0] OPC_SUB  = 4'd2;
  localparam logic [3:0] OPC_STO  = 4'd3;
  localparam logic [3:0] OPC_LDA  = 4'd5;
  localparam logic [3:0] OPC_BRA  = 4'd6;
  localparam logic [3:0] OPC_BRZ  = 4'd7;
  localparam logic [3:0] OPC_BRP  = 4'd8;

  localparam logic [9:0] INSTR_IN  = 10'd901;
  localparam logic [9:0] INSTR_OUT = 10'd902;
  localparam logic [9:0] WORD_MAX  = 10'd999;
  localparam logic [9:0] INBOX_MAX = 10'd99;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] address;
    logic [9:0] word;
    logic [9:0] inbox_value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] value;
    logic [6:0] next_pc;
  } rsp_t;

  // Decoded instruction
  typedef struct packed {
    logic [3:0] code;
    logic [6:0] arg;
    logic       is_in;
    logic       is_out;
  } dec_t;

  // Architectural update produced by one executed instruction
  typedef struct packed {
    logic [9:0] acc;
    logic       wrap;
    logic       stop;
    status_e    status;
    logic [6:0] pc;
  } exe_t;

  // Split a word (0..999) into hundreds digit and remainder.
  // w / 100 == (w * 41) >> 12 for every w below 1000.
  function automatic dec_t decode_word(logic [9:0] w);
    logic [15:0] prod;
    logic [3:0]  q;
    logic [9:0]  rem;
    dec_t        d;
    prod     = 16'(w) * 16'd41;
    q        = prod[15:12];
    rem      = w - 10'(10'(q) * 10'd100);
    d.code   = q;
    d.arg    = rem[6:0];
    d.is_in  = (w == INSTR_IN);
    d.is_out = (w == INSTR_OUT);
    return d;
  endfunction

endpackage

/* design/lmc_ram.sv */
module lmc_ram import lmc_pkg::*; #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lmc_exec.sv */
module lmc_exec import lmc_pkg::*; (
  input  dec_t       dec_i,
  input  logic [9:0] operand_i,
  input  logic [9:0] acc_i,
  input  logic       wrap_i,
  input  logic [9:0] inbox_i,
  input  logic [6:0] pc_i,
  output exe_t       exe_o
);

  logic [10:0] sum;

  assign sum = {1'b0, acc_i} + {1'b0, operand_i};

  always_comb begin
    exe_o.acc    = acc_i;
    exe_o.wrap   = wrap_i;
    exe_o.stop   = 1'b0;
    exe_o.status = ST_RAN;
    exe_o.pc     = pc_i;
    if (dec_i.is_in) begin
      if (inbox_i > INBOX_MAX) begin
        exe_o.stop   = 1'b1;
        exe_o.status = ST_RANGE;
      end else begin
        exe_o.acc = inbox_i;
      end
    end else if (dec_i.is_out) begin
      exe_o.status = ST_OUTPUT;
    end else begin
      case (dec_i.code)
        OPC_HALT: begin
          exe_o.stop   = 1'b1;
          exe_o.status = ST_HALTED;
        end
        OPC_ADD: begin
          if (sum > {1'b0, WORD_MAX}) begin
            exe_o.acc  = '0;
            exe_o.wrap = 1'b1;
          end else begin
            exe_o.acc  = sum[9:0];
            exe_o.wrap = 1'b0;
          end
        end
        OPC_SUB: begin
          if (operand_i > acc_i) begin
            exe_o.acc  = '0;
            exe_o.wrap = 1'b1;
          end else begin
            exe_o.acc  = acc_i - operand_i;
            exe_o.wrap = 1'b0;
          end
        end
        OPC_STO: ;  // write already done during decode
        OPC_LDA: exe_o.acc = operand_i;
        OPC_BRA: exe_o.pc = dec_i.arg;
        OPC_BRZ: begin
          if (acc_i == '0 && !wrap_i) exe_o.pc = dec_i.arg;
        end
        OPC_BRP: begin
          if (!wrap_i) exe_o.pc = dec_i.arg;
        end
        default: begin
          exe_o.stop   = 1'b1;
          exe_o.status = ST_BADOP;
        end
      endcase
    end
  end

endmodule

/* design/little_man_computer_core.sv */
// Decimal teaching machine: 100 mailboxes of three-digit words, program
// counter, accumulator and wrap flag.
//
// Request channel: req_i is taken at a rising edge where start_i is high and
// busy_o is low. op selects load mailbox, step one instruction, or restart.
// Result channel: every request yields one result in rsp_o, marked by done_o
// for exactly one cycle. There is no back-pressure on results.
//
// Sequencing:
//   load, restart, unused op, step while stopped : result registered in the
//     following cycle, next request may follow back to back.
//   step : fetch read, then decode + operand read or store write, then
//     execute; busy_o is high in the decode and execute states. The single
//     mailbox RAM port pair and its registered read set this sequence.
//
// Reset (rst_ni low, async): pc, accumulator, wrap flag and stop mark clear,
// and a per-mailbox valid vector clears so every mailbox reads as zero until
// written. No clearing pass is needed; the block is ready right after reset.
module little_man_computer_core import lmc_pkg::*; #(
  parameter int MAILBOXES = 100
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int AW = $clog2(MAILBOXES);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECODE = 3'b010,
    S_EXEC   = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [6:0]           pc_q, pc_d;
  logic [9:0]           acc_q, acc_d;
  logic                 wrap_q, wrap_d;
  logic                 stop_q, stop_d;
  logic [MAILBOXES-1:0] vld_q, vld_d;
  logic                 rd_vld_q;
  logic [9:0]           inbox_q, inbox_d;
  dec_t                 dec_q, dec_d;
  logic                 done_q, done_d;
  rsp_t                 rsp_q, rsp_d;

  // mailbox RAM port signals
  logic          we;
  logic [AW-1:0] waddr;
  logic [9:0]    wdata;
  logic [AW-1:0] raddr;
  logic [9:0]    rdata;
  logic [9:0]    rword;    // RAM data, zero if never written

  logic [9:0]    load_word;
  logic [6:0]    pc_inc;
  dec_t          dec;
  exe_t          exe;

  lmc_ram #(
    .WIDTH(10),
    .DEPTH(MAILBOXES)
  ) u_mbox (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  lmc_exec u_exec (
    .dec_i    (dec_q),
    .operand_i(rword),
    .acc_i    (acc_q),
    .wrap_i   (wrap_q),
    .inbox_i  (inbox_q),
    .pc_i     (pc_q),
    .exe_o    (exe)
  );

  assign rword     = rd_vld_q ? rdata : '0;
  assign dec       = decode_word(rword);
  assign load_word = (req_i.word > WORD_MAX) ? WORD_MAX : req_i.word;
  assign pc_inc    = (pc_q == 7'(MAILBOXES - 1)) ? '0 : pc_q + 7'd1;

  // operand from the decoded argument in decode, fetch from pc in all other states
  assign raddr = (state_q == S_DECODE) ? dec.arg[AW-1:0] : pc_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    acc_d   = acc_q;
    wrap_d  = wrap_q;
    stop_d  = stop_q;
    inbox_d = inbox_q;
    dec_d   = dec_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = req_i.address[AW-1:0];
    wdata   = load_word;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_i.op)
            OP_LOAD: begin
              we     = (req_i.address < 7'(MAILBOXES));
              done_d = 1'b1;
              rsp_d  = '{status: ST_LOADED, value: acc_q, next_pc: pc_q};
            end
            OP_RESTART: begin
              pc_d   = '0;
              acc_d  = '0;
              wrap_d = 1'b0;
              stop_d = 1'b0;
              done_d = 1'b1;
              rsp_d  = '{status: ST_RAN, value: '0, next_pc: '0};
            end
            OP_STEP: begin
              if (stop_q) begin
                done_d = 1'b1;
                rsp_d  = '{status: ST_STOPPED, value: acc_q, next_pc: pc_q};
              end else begin
                // fetch read of mailbox[pc] issued this cycle
                inbox_d = req_i.inbox_value;
                state_d = S_DECODE;
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = '{status: ST_RAN, value: acc_q, next_pc: pc_q};
            end
          endcase
        end
      end
      S_DECODE: begin
        // instruction word arrives; operand read of mailbox[arg] issued
        dec_d   = dec;
        pc_d    = pc_inc;
        state_d = S_EXEC;
        if (dec.code == OPC_STO) begin
          we    = 1'b1;
          waddr = dec.arg[AW-1:0];
          wdata = acc_q;
        end
      end
      S_EXEC: begin
        acc_d   = exe.acc;
        wrap_d  = exe.wrap;
        stop_d  = stop_q | exe.stop;
        pc_d    = exe.pc;
        done_d  = 1'b1;
        rsp_d   = '{status: exe.status, value: exe.acc, next_pc: exe.pc};
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (we) vld_d[waddr] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      acc_q    <= '0;
      wrap_q   <= 1'b0;
      stop_q   <= 1'b0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      acc_q    <= acc_d;
      wrap_q   <= wrap_d;
      stop_q   <= stop_d;
      vld_q    <= vld_d;
      rd_vld_q <= vld_q[raddr];
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inbox_q <= inbox_d;
    dec_q   <= dec_d;
    rsp_q   <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
